[rtl/ipft_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipft_pkg
// Types, constants and helpers shared by the IPv4 five-tuple extractor.
// ----------------------------------------------------------------------------
package ipft_pkg;

  // one frame byte as it arrives
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // one result per frame
  typedef struct packed {
    logic        frame_ok;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  protocol_number;
  } out_t;

  // everything captured from one frame, handed from the front to the back
  typedef struct packed {
    logic [15:0] byte_count;
    logic [15:0] ether_kind;
    logic [3:0]  header_words;
    logic [7:0]  proto_seen;
    logic [31:0] src_addr_seen;
    logic [31:0] dst_addr_seen;
    logic [15:0] src_port_seen;
    logic [15:0] dst_port_seen;
  } summary_t;

  // queue write request
  typedef struct packed {
    logic     valid;
    summary_t data;
  } push_t;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp      = 8'd6;
  localparam logic [7:0]  ProtoUdp      = 8'd17;
  localparam logic [15:0] EthHdrBytes   = 16'd14;
  localparam logic [15:0] MinIpv4Frame  = 16'd34;
  localparam logic [15:0] TcpHdrBytes   = 16'd20;
  localparam logic [15:0] UdpHdrBytes   = 16'd8;
  localparam logic [15:0] CountMax      = 16'hFFFF;

  // byte positions within the frame
  localparam logic [15:0] PosEtherHi  = 16'd12;
  localparam logic [15:0] PosEtherLo  = 16'd13;
  localparam logic [15:0] PosProto    = 16'd23;
  localparam logic [15:0] PosSrcFirst = 16'd26;
  localparam logic [15:0] PosSrcLast  = 16'd29;
  localparam logic [15:0] PosDstFirst = 16'd30;
  localparam logic [15:0] PosDstLast  = 16'd33;

  // 14 plus four bytes per header word
  function automatic logic [15:0] port_offset(input logic [3:0] words);
    port_offset = EthHdrBytes + {10'd0, words, 2'b00};
  endfunction

endpackage

[rtl/ipft_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipft_front
// Byte intake: counts frame bytes, captures header fields and pushes a
// frame summary into the queue on the last byte.
// ----------------------------------------------------------------------------
module ipft_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ipft_pkg::in_t   in_data_i,
  input  logic            full_i,
  output ipft_pkg::push_t push_o
);

  ipft_pkg::summary_t st_q, st_d;
  logic               accept;
  logic [15:0]        pos;
  logic [7:0]         b;
  logic [3:0]         words;
  logic [15:0]        toff;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign pos        = st_q.byte_count;
  assign b          = in_data_i.data_byte;

  // header length is usable on the very byte that carries it
  assign words = (pos == ipft_pkg::EthHdrBytes) ? b[3:0] : st_q.header_words;
  assign toff  = ipft_pkg::port_offset(words);

  always_comb begin
    st_d = st_q;
    if (pos == ipft_pkg::PosEtherHi || pos == ipft_pkg::PosEtherLo) begin
      st_d.ether_kind = {st_q.ether_kind[7:0], b};
    end
    if (pos == ipft_pkg::EthHdrBytes) begin
      st_d.header_words = b[3:0];
    end
    if (pos == ipft_pkg::PosProto) begin
      st_d.proto_seen = b;
    end
    if (pos >= ipft_pkg::PosSrcFirst && pos <= ipft_pkg::PosSrcLast) begin
      st_d.src_addr_seen = {st_q.src_addr_seen[23:0], b};
    end
    if (pos >= ipft_pkg::PosDstFirst && pos <= ipft_pkg::PosDstLast) begin
      st_d.dst_addr_seen = {st_q.dst_addr_seen[23:0], b};
    end
    if (pos >= ipft_pkg::EthHdrBytes) begin
      if (pos == toff || pos == toff + 16'd1) begin
        st_d.src_port_seen = {st_q.src_port_seen[7:0], b};
      end
      if (pos == toff + 16'd2 || pos == toff + 16'd3) begin
        st_d.dst_port_seen = {st_q.dst_port_seen[7:0], b};
      end
    end
    if (pos != ipft_pkg::CountMax) begin
      st_d.byte_count = pos + 16'd1;
    end
  end

  assign push_o.valid = accept && in_data_i.last_byte;
  assign push_o.data  = st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept) begin
      if (in_data_i.last_byte) begin
        st_q <= '0;
      end else begin
        st_q <= st_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // capture state starts over after every last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.last_byte |=> st_q.byte_count == 16'd0)
    else $error("frame state not cleared after last byte");
`endif

endmodule

[rtl/ipft_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipft_queue
// Small queue of frame summaries between intake and result stage.
// ----------------------------------------------------------------------------
module ipft_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ipft_pkg::push_t    push_i,
  output logic               full_o,
  output logic               valid_o,
  output ipft_pkg::summary_t data_o,
  input  logic               pop_i
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ipft_pkg::summary_t    mem_q [DEPTH];
  logic [PW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count beyond depth");
  // the intake stalls while full, so no summary is ever dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("summary pushed into full queue");
`endif

endmodule

[rtl/ipft_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipft_back
// Result stage: judges a frame summary and holds the five-tuple in an
// output register until the consumer takes it.
// ----------------------------------------------------------------------------
module ipft_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  ipft_pkg::summary_t q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ipft_pkg::out_t     out_data_o
);

  logic           out_valid_q;
  ipft_pkg::out_t out_q, out_d;
  logic [15:0]    len;
  logic [15:0]    toff;
  logic           is_tcp, is_udp;
  logic           ok, ported;

  assign len    = q_data_i.byte_count;
  assign toff   = ipft_pkg::port_offset(q_data_i.header_words);
  assign is_tcp = (q_data_i.proto_seen == ipft_pkg::ProtoTcp);
  assign is_udp = (q_data_i.proto_seen == ipft_pkg::ProtoUdp);

  always_comb begin
    ok = (len >= ipft_pkg::EthHdrBytes)
      && (q_data_i.ether_kind == ipft_pkg::EtherTypeIpv4)
      && (len >= ipft_pkg::MinIpv4Frame);
    if (is_tcp) begin
      ok = ok && (len >= toff + ipft_pkg::TcpHdrBytes);
    end else if (is_udp) begin
      ok = ok && (len >= toff + ipft_pkg::UdpHdrBytes);
    end
    ported = ok && (is_tcp || is_udp);
  end

  always_comb begin
    out_d.frame_ok        = ok;
    out_d.source_address  = ok ? q_data_i.src_addr_seen : '0;
    out_d.dest_address    = ok ? q_data_i.dst_addr_seen : '0;
    out_d.source_port     = ported ? q_data_i.src_port_seen : '0;
    out_d.dest_port       = ported ? q_data_i.dst_port_seen : '0;
    out_d.protocol_number = ok ? q_data_i.proto_seen : '0;
  end

  assign pop_o       = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

`ifndef NO_ASSERTIONS
  // a rejected frame carries an all-zero tuple
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.frame_ok |-> out_q.source_address == '0
      && out_q.dest_address == '0 && out_q.protocol_number == '0
      && out_q.source_port == '0 && out_q.dest_port == '0)
    else $error("rejected frame with nonzero fields");
  // ports only for tcp and udp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.protocol_number != ipft_pkg::ProtoTcp
      && out_q.protocol_number != ipft_pkg::ProtoUdp
      |-> out_q.source_port == '0 && out_q.dest_port == '0)
    else $error("ports reported for non-tcp/udp frame");
`endif

endmodule

[rtl/ipv4_five_tuple_extractor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_five_tuple_extractor
// Pulls the IPv4 five-tuple out of an Ethernet frame streamed a byte a cycle.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per cycle while the queue has room, with no gaps
// needed between frames. The intake captures the EtherType, header length,
// protocol, addresses and the two port words as they pass; on the last byte
// a summary goes into a QUEUE_DEPTH-entry queue, and the result stage judges
// it and presents one result per frame from its output register. The input
// stalls only while that queue is full, i.e. when results back up at the output.
// ----------------------------------------------------------------------------
module ipv4_five_tuple_extractor #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ipft_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ipft_pkg::out_t out_data_o
);

  ipft_pkg::push_t    push;
  logic               q_full;
  logic               q_valid;
  ipft_pkg::summary_t q_data;
  logic               q_pop;

  ipft_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (q_full),
    .push_o     (push)
  );

  ipft_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  ipft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[test/ipv4_five_tuple_extractor_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_five_tuple_extractor_chk
// Follows each frame byte by byte, predicts its five-tuple and compares it
// against every result the extractor hands out.
// ----------------------------------------------------------------------------
module ipv4_five_tuple_extractor_chk (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  ipft_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  ipft_pkg::out_t out_data_i,
  output int             fail_count_o,
  output int             tuples_pending_o
);

  // frame being parsed
  logic [15:0] frame_len;
  logic [15:0] eth_type;
  logic [3:0]  ihl_words;
  logic [7:0]  ip_proto;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] l4_sport;
  logic [15:0] l4_dport;

  ipft_pkg::out_t tuple_q[$];
  ipft_pkg::out_t want_tuple;
  int             mismatches;

  task automatic clear_frame();
    frame_len = '0;
    eth_type  = '0;
    ihl_words = '0;
    ip_proto  = '0;
    src_ip    = '0;
    dst_ip    = '0;
    l4_sport  = '0;
    l4_dport  = '0;
  endtask

  function automatic logic frame_accepted(input int len);
    int toff;
    toff = int'(ipft_pkg::EthHdrBytes) + 4 * int'(ihl_words);
    if (len < int'(ipft_pkg::EthHdrBytes)) return 1'b0;
    if (eth_type != ipft_pkg::EtherTypeIpv4) return 1'b0;
    if (len < int'(ipft_pkg::MinIpv4Frame)) return 1'b0;
    if (ip_proto == ipft_pkg::ProtoTcp) begin
      return len >= toff + int'(ipft_pkg::TcpHdrBytes);
    end
    if (ip_proto == ipft_pkg::ProtoUdp) begin
      return len >= toff + int'(ipft_pkg::UdpHdrBytes);
    end
    return 1'b1;
  endfunction

  task automatic absorb_byte(input ipft_pkg::in_t req);
    int             pos;
    int             words;
    int             toff;
    int             hdr;
    logic [7:0]     b;
    logic           ok;
    logic           ported;
    ipft_pkg::out_t tuple;
    pos = int'(frame_len);
    hdr = int'(ipft_pkg::EthHdrBytes);
    b   = req.data_byte;
    if (pos == int'(ipft_pkg::PosEtherHi) || pos == int'(ipft_pkg::PosEtherLo)) begin
      eth_type = {eth_type[7:0], b};
    end
    if (pos == hdr) ihl_words = b[3:0];
    if (pos == int'(ipft_pkg::PosProto)) ip_proto = b;
    if (pos >= int'(ipft_pkg::PosSrcFirst) && pos <= int'(ipft_pkg::PosSrcLast)) begin
      src_ip = {src_ip[23:0], b};
    end
    if (pos >= int'(ipft_pkg::PosDstFirst) && pos <= int'(ipft_pkg::PosDstLast)) begin
      dst_ip = {dst_ip[23:0], b};
    end
    // the length nibble already steers the port capture on its own byte
    words = (pos == hdr) ? int'(b[3:0]) : int'(ihl_words);
    if (pos >= hdr) begin
      toff = hdr + 4 * words;
      if (pos == toff || pos == toff + 1) l4_sport = {l4_sport[7:0], b};
      if (pos == toff + 2 || pos == toff + 3) l4_dport = {l4_dport[7:0], b};
    end
    if (frame_len != ipft_pkg::CountMax) frame_len = frame_len + 16'd1;
    if (req.last_byte) begin
      ok     = frame_accepted(int'(frame_len));
      ported = ok && (ip_proto == ipft_pkg::ProtoTcp || ip_proto == ipft_pkg::ProtoUdp);
      tuple.frame_ok        = ok;
      tuple.source_address  = ok ? src_ip : '0;
      tuple.dest_address    = ok ? dst_ip : '0;
      tuple.source_port     = ported ? l4_sport : '0;
      tuple.dest_port       = ported ? l4_dport : '0;
      tuple.protocol_number = ok ? ip_proto : '0;
      tuple_q.push_back(tuple);
      clear_frame();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      tuple_q.delete();
      mismatches = 0;
      fail_count_o     <= 0;
      tuples_pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (tuple_q.size() == 0) begin
          $error("result with no frame outstanding");
          mismatches++;
        end else begin
          want_tuple = tuple_q.pop_front();
          check_field("frame_ok", 32'(want_tuple.frame_ok), 32'(out_data_i.frame_ok));
          check_field("source_address", want_tuple.source_address,
                      out_data_i.source_address);
          check_field("dest_address", want_tuple.dest_address,
                      out_data_i.dest_address);
          check_field("source_port", 32'(want_tuple.source_port),
                      32'(out_data_i.source_port));
          check_field("dest_port", 32'(want_tuple.dest_port),
                      32'(out_data_i.dest_port));
          check_field("protocol_number", 32'(want_tuple.protocol_number),
                      32'(out_data_i.protocol_number));
        end
      end
      if (in_valid_i && !in_stall_i) absorb_byte(in_data_i);
      fail_count_o     <= mismatches;
      tuples_pending_o <= tuple_q.size();
    end
  end

endmodule

[test/ipv4_five_tuple_extractor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_five_tuple_extractor_tb
// Streams directed and random Ethernet frames into the extractor under
// changing sender gaps and receiver stalls; the checker grades the results.
// ----------------------------------------------------------------------------
module ipv4_five_tuple_extractor_tb;

  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 16;
  localparam int PhaseBytes  = 400;
  localparam int PhaseFrames = 16;

  logic           clk;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  ipft_pkg::in_t  in_data   = '0;
  logic           out_stall = 1'b0;
  logic           in_stall;
  logic           out_valid;
  ipft_pkg::out_t out_data;

  int fail_count;
  int tuples_pending;
  int cycle_count = 0;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int phase_bytes;
  int phase_frames;

  ipv4_five_tuple_extractor DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  ipv4_five_tuple_extractor_chk tuple_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .fail_count_o    (fail_count),
    .tuples_pending_o(tuples_pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic push_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: lst};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // header fields land on their byte positions, the rest is fill
  task automatic send_frame(input logic [15:0] eth, input logic [7:0] ver_ihl,
                            input logic [7:0] proto, input int len, input int fill);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom) : fill[7:0];
      case (i)
        12: b = eth[15:8];
        13: b = eth[7:0];
        14: b = ver_ihl;
        23: b = proto;
        default: ;
      endcase
      push_byte(b, i == len - 1);
    end
  endtask

  task automatic send_random_frame();
    int          roll;
    int          pick;
    int          need;
    int          len;
    logic [3:0]  ihl;
    logic [3:0]  ver;
    logic [7:0]  proto;
    logic [15:0] eth;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
    ver  = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'd4;
    if (pick < 4) proto = ipft_pkg::ProtoTcp;
    else if (pick < 8) proto = ipft_pkg::ProtoUdp;
    else proto = 8'($urandom);
    need = int'(ipft_pkg::EthHdrBytes) + 4 * int'(ihl);
    if (proto == ipft_pkg::ProtoTcp) need += int'(ipft_pkg::TcpHdrBytes);
    else if (proto == ipft_pkg::ProtoUdp) need += int'(ipft_pkg::UdpHdrBytes);
    if (need < int'(ipft_pkg::MinIpv4Frame)) need = int'(ipft_pkg::MinIpv4Frame);
    eth = ipft_pkg::EtherTypeIpv4;
    if (roll < 75) begin
      len = need + $urandom_range(0, 16);
    end else if (roll < 90) begin
      // often truncated, sometimes with a foreign ethertype too
      len = $urandom_range(1, need + 2);
      if ($urandom_range(0, 1) == 1) eth = 16'($urandom);
    end else begin
      len   = $urandom_range(1, 64);
      eth   = 16'($urandom);
      ver   = 4'($urandom);
      ihl   = 4'($urandom);
      proto = 8'($urandom);
    end
    send_frame(eth, {ver, ihl}, proto, len, -1);
    phase_bytes += len;
    phase_frames++;
  endtask

  task automatic send_directed_frames();
    send_frame(ipft_pkg::EtherTypeIpv4, 8'h45, ipft_pkg::ProtoTcp, 1, -1);
    send_frame(ipft_pkg::EtherTypeIpv4, 8'h45, ipft_pkg::ProtoTcp, 13, -1);
    send_frame(ipft_pkg::EtherTypeIpv4, 8'h45, ipft_pkg::ProtoTcp, 14, -1);
    send_frame(16'h86DD, 8'h45, ipft_pkg::ProtoTcp, 60, -1);
    send_frame(ipft_pkg::EtherTypeIpv4, 8'h45, 8'd1, 33, -1);
    send_frame(ipft_pkg::EtherTypeIpv4, 8'h45, 8'd1, 34, -1);
    send_frame(ipft_pkg::EtherTypeIpv4, 8'h45, ipft_pkg::ProtoTcp, 54, -1);
    send_frame(ipft_pkg::EtherTypeIpv4, 8'h45, ipft_pkg::ProtoTcp, 53, -1);
    send_frame(ipft_pkg::EtherTypeIpv4, 8'h45, ipft_pkg::ProtoUdp, 42, -1);
    send_frame(ipft_pkg::EtherTypeIpv4, 8'h45, ipft_pkg::ProtoUdp, 41, -1);
    // zero header length: ports start on the length byte itself
    send_frame(ipft_pkg::EtherTypeIpv4, 8'h40, ipft_pkg::ProtoUdp, 34, -1);
    // ports overlapping the destination address
    send_frame(ipft_pkg::EtherTypeIpv4, 8'h44, ipft_pkg::ProtoUdp, 38, -1);
    send_frame(ipft_pkg::EtherTypeIpv4, 8'hFF, ipft_pkg::ProtoTcp, 94, -1);
    send_frame(ipft_pkg::EtherTypeIpv4, 8'hFF, ipft_pkg::ProtoTcp, 93, -1);
    send_frame(16'hFFFF, 8'hFF, 8'hFF, 80, 8'hFF);
    send_frame(ipft_pkg::EtherTypeIpv4, 8'hFF, 8'hFF, 74, 8'hFF);
    send_frame(16'h0000, 8'h00, 8'h00, 34, 8'h00);
    send_frame(ipft_pkg::EtherTypeIpv4, 8'h00, 8'h00, 34, 8'h00);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct   = (phase == 0) ? 7 : (phase == 1) ? 70 : 0;
      stall_pct = (phase == 0) ? 70 : (phase == 1) ? 7 : 0;
      if (phase == 0) send_directed_frames();
      phase_bytes  = 0;
      phase_frames = 0;
      while (phase_bytes < PhaseBytes || phase_frames < PhaseFrames) begin
        send_random_frame();
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (tuples_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ipft_pkg.sv
rtl/ipft_front.sv
rtl/ipft_queue.sv
rtl/ipft_back.sv
rtl/ipv4_five_tuple_extractor.sv
test/ipv4_five_tuple_extractor_chk.sv
test/ipv4_five_tuple_extractor_tb.sv
